/* rtl/core/u8dec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int REM_W  = 2;

    localparam logic [CP_W-1:0]   CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [BYTE_W-1:0] MASK_CONT      = 8'h3F;
    localparam logic [BYTE_W-1:0] MASK_LEAD2     = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_LEAD3     = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_LEAD4     = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_ASCII     = 8'h7F;

    // Upper bounds of the lead byte classes.
    localparam logic [BYTE_W-1:0] LEAD_ASCII_MAX = 8'd127;
    localparam logic [BYTE_W-1:0] LEAD_CONT_MAX  = 8'd191;
    localparam logic [BYTE_W-1:0] LEAD2_MAX      = 8'd223;
    localparam logic [BYTE_W-1:0] LEAD3_MAX      = 8'd239;
    localparam logic [BYTE_W-1:0] LEAD4_MAX      = 8'd244;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic             replaced;
        logic [LEN_W-1:0] sequence_length;
    } result_t;

endpackage

/* rtl/core/u8dec_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_core
// Sequence state and per-byte decode. One byte is consumed on each cycle
// that advance is high; emit flags a finished code point in that cycle.
// ----------------------------------------------------------------------------
module u8dec_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [u8dec_pkg::BYTE_W-1:0]  byte_value,
    output logic                          emit,
    output u8dec_pkg::result_t            result
);

    logic [u8dec_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [u8dec_pkg::CP_W-1:0]  partial_reg, partial_next;
    logic [u8dec_pkg::LEN_W-1:0] len_reg, len_next;

    logic [u8dec_pkg::BYTE_W-1:0] cont_bits;
    logic [u8dec_pkg::CP_W-1:0]   cont_shifted;
    logic [u8dec_pkg::CP_W-1:0]   merged;
    logic [u8dec_pkg::REM_W-1:0]  rem_dec;
    logic [u8dec_pkg::LEN_W-1:0]  len_inc;

    assign cont_bits = byte_value & u8dec_pkg::MASK_CONT;
    assign rem_dec   = rem_reg - 2'd1;
    assign len_inc   = len_reg + 3'd1;

    // Continuation weight follows the count of bytes still expected after it.
    always_comb begin
        case (rem_dec)
            2'd0:    cont_shifted = {13'd0, cont_bits};
            2'd1:    cont_shifted = {7'd0, cont_bits, 6'd0};
            default: cont_shifted = {1'b0, cont_bits, 12'd0};
        endcase
    end

    assign merged = partial_reg | cont_shifted;

    always_comb begin
        rem_next        = rem_reg;
        partial_next    = partial_reg;
        len_next        = len_reg;
        emit            = 1'b0;
        result          = '0;
        if (rem_reg == '0) begin
            if (byte_value <= u8dec_pkg::LEAD_ASCII_MAX) begin
                emit                   = 1'b1;
                result.code_point      = {13'd0, byte_value & u8dec_pkg::MASK_ASCII};
                result.sequence_length = 3'd1;
            end else if (byte_value <= u8dec_pkg::LEAD_CONT_MAX) begin
                emit                   = 1'b1;
                result.code_point      = u8dec_pkg::CP_REPLACEMENT;
                result.replaced        = 1'b1;
                result.sequence_length = 3'd1;
            end else if (byte_value <= u8dec_pkg::LEAD2_MAX) begin
                partial_next = {7'd0, byte_value & u8dec_pkg::MASK_LEAD2, 6'd0};
                rem_next     = 2'd1;
                len_next     = 3'd1;
            end else if (byte_value <= u8dec_pkg::LEAD3_MAX) begin
                partial_next = {1'b0, byte_value & u8dec_pkg::MASK_LEAD3, 12'd0};
                rem_next     = 2'd2;
                len_next     = 3'd1;
            end else if (byte_value <= u8dec_pkg::LEAD4_MAX) begin
                partial_next = {byte_value[2:0] & u8dec_pkg::MASK_LEAD4[2:0], 18'd0};
                rem_next     = 2'd3;
                len_next     = 3'd1;
            end else begin
                emit                   = 1'b1;
                result.code_point      = u8dec_pkg::CP_REPLACEMENT;
                result.replaced        = 1'b1;
                result.sequence_length = 3'd1;
            end
        end else begin
            // Every byte inside an open sequence counts as a continuation.
            rem_next = rem_dec;
            if (rem_dec == '0) begin
                emit                   = 1'b1;
                result.code_point      = merged;
                result.sequence_length = len_inc;
                partial_next           = '0;
                len_next               = '0;
            end else begin
                partial_next = merged;
                len_next     = len_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            partial_reg <= '0;
            len_reg     <= '0;
        end else if (advance) begin
            rem_reg     <= rem_next;
            partial_reg <= partial_next;
            len_reg     <= len_next;
        end
    end

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg == '0) |-> (len_reg == '0))
        else $error("u8dec_core: length count left over with no open sequence");

    a_open_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg != '0) |-> (len_reg != '0 && len_reg + 3'(rem_reg) <= 3'd4))
        else $error("u8dec_core: open sequence length out of range");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && rem_reg != '0) |=> (rem_reg == $past(rem_reg) - 2'd1))
        else $error("u8dec_core: continuation did not count down");

    a_replaced_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit && result.replaced) |->
            (result.sequence_length == 3'd1 && rem_reg == '0))
        else $error("u8dec_core: replacement outside a lead byte");

endmodule

/* rtl/core/utf8_byte_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// UTF-8 byte stream to code point decoder with registered input and output.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one raw byte per item in s_tdata. The master
//   channel gives one item per finished sequence: m_tdata carries the code
//   point and the number of bytes consumed, m_tuser flags U+FFFD given for
//   an invalid lead byte. Bytes inside an open sequence give no item.
//   Throughput is one byte per clock while the receiver takes items. A byte
//   is registered in the input register, then its result is registered in
//   the output register and offered on the master side.
//   The only feedback loop is the sequence state update in u8dec_core.
//   When the receiver stalls, the pending result holds and one more byte
//   is still taken into the input register; after that s_tready drops
//   until the output register drains.
//   A synchronous low aresetn empties both registers and returns the
//   decoder to expecting a lead byte.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] sequence_length
    output logic        m_tuser    // [0] replaced
);

    logic                               in_valid_reg, in_valid_next;
    logic [u8dec_pkg::BYTE_W-1:0]       in_byte_reg;
    logic                               out_valid_reg, out_valid_next;
    u8dec_pkg::result_t                 out_reg;

    logic               advance;
    logic               emit;
    u8dec_pkg::result_t result;

    // A byte moves into the decoder only when the output register has room,
    // since any byte may finish a sequence.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    u8dec_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .byte_value (in_byte_reg),
        .emit       (emit),
        .result     (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && emit) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.sequence_length, out_reg.code_point};
    assign m_tuser  = out_reg.replaced;

endmodule

/* test/utf8_byte_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_tb
// Self-checking bench for the UTF-8 byte stream decoder. Bytes go in on the
// slave channel; a byte-level decoder model in the bench predicts each code
// point, and every item on the master channel is compared field by field.
// A directed opening covers the lead byte classes, overlong and largest
// sequences and unchecked continuations. Random traffic follows, mostly
// well-formed sequences, under phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_tb;

    localparam int CLK_PERIOD  = 10;
    localparam int BYTE_TARGET = 1550;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 10;
    localparam int CP_W        = u8dec_pkg::CP_W;

    // Tracks the decoder state one byte at a time and keeps the code points
    // still owed by the block, oldest first.
    class code_point_board;
        u8dec_pkg::result_t owed_q[$];
        logic [1:0]  remaining;
        logic [20:0] partial;
        logic [2:0]  taken;
        int          n_errors;
        int          n_checked;
        int          n_replaced;
        int          n_multi;

        function new();
            remaining  = '0;
            partial    = '0;
            taken      = '0;
            n_errors   = 0;
            n_checked  = 0;
            n_replaced = 0;
            n_multi    = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            n_errors++;
        endtask

        function int pending();
            return owed_q.size();
        endfunction

        function void owe(input logic [20:0] cp, input logic repl, input logic [2:0] len);
            u8dec_pkg::result_t r;
            r.code_point      = cp;
            r.replaced        = repl;
            r.sequence_length = len;
            owed_q.push_back(r);
        endfunction

        function void note_byte(input logic [7:0] b);
            if (remaining == 0) begin
                if (b <= u8dec_pkg::LEAD_ASCII_MAX) begin
                    owe(CP_W'(b & u8dec_pkg::MASK_ASCII), 1'b0, 3'd1);
                end else if (b <= u8dec_pkg::LEAD_CONT_MAX || b > u8dec_pkg::LEAD4_MAX) begin
                    owe(u8dec_pkg::CP_REPLACEMENT, 1'b1, 3'd1);
                end else begin
                    if (b <= u8dec_pkg::LEAD2_MAX) begin
                        partial   = CP_W'(b & u8dec_pkg::MASK_LEAD2) << 6;
                        remaining = 2'd1;
                    end else if (b <= u8dec_pkg::LEAD3_MAX) begin
                        partial   = CP_W'(b & u8dec_pkg::MASK_LEAD3) << 12;
                        remaining = 2'd2;
                    end else begin
                        partial   = CP_W'(b & u8dec_pkg::MASK_LEAD4) << 18;
                        remaining = 2'd3;
                    end
                    taken = 3'd1;
                end
            end else begin
                // Whatever its top bits, a byte inside an open sequence only
                // contributes its low six bits.
                partial   = partial |
                            (CP_W'(b & u8dec_pkg::MASK_CONT) << (6 * (remaining - 1)));
                remaining = remaining - 2'd1;
                taken     = taken + 3'd1;
                if (remaining == 0) begin
                    owe(partial, 1'b0, taken);
                    partial = '0;
                    taken   = '0;
                end
            end
        endfunction

        task check_result(input logic [20:0] cp, input logic repl, input logic [2:0] len);
            u8dec_pkg::result_t r;
            if (owed_q.size() == 0) begin
                report($sformatf("code point 0x%06h arrived with nothing owed", cp));
            end else begin
                r = owed_q.pop_front();
                n_checked++;
                if (r.replaced) n_replaced++;
                if (r.sequence_length > 1) n_multi++;
                if (cp !== r.code_point)
                    report($sformatf("code_point 0x%06h, predicted 0x%06h", cp, r.code_point));
                if (repl !== r.replaced)
                    report($sformatf("replaced %0b, predicted %0b", repl, r.replaced));
                if (len !== r.sequence_length)
                    report($sformatf("sequence_length %0d, predicted %0d",
                                     len, r.sequence_length));
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [20:0] code_point, [23:21] sequence_length
    logic        m_tuser;   // [0] replaced

    code_point_board board = new();
    int idle_pct    = 0;
    int stall_pct   = 0;
    int bytes_sent  = 0;
    int cycle_count = 0;

    utf8_byte_stream_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d code points owed",
                     cycle_count, board.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: checks every accepted item and chooses the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata[20:0], m_tuser, m_tdata[23:21]);
        m_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
    end

    // Offers one byte, possibly after an idle gap, and returns at the edge
    // that accepts it. Valid stays high for a following byte with no gap.
    task automatic send_byte(input logic [7:0] b);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        board.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_random_run();
        int          pick;
        int          n_cont;
        logic [7:0]  lead;
        pick = $urandom_range(99);
        if (pick < 72) begin
            // Well-formed sequence of a random length with random content.
            case ($urandom_range(3))
                0: begin
                    lead   = 8'($urandom_range(127));
                    n_cont = 0;
                end
                1: begin
                    lead   = 8'($urandom_range(223, 192));
                    n_cont = 1;
                end
                2: begin
                    lead   = 8'($urandom_range(239, 224));
                    n_cont = 2;
                end
                default: begin
                    lead   = 8'($urandom_range(244, 240));
                    n_cont = 3;
                end
            endcase
            send_byte(lead);
            repeat (n_cont) send_byte(8'h80 | 8'($urandom_range(63)));
        end else if (pick < 82) begin
            // Stray continuation or a lead byte above the valid range.
            send_byte($urandom_range(1) ? 8'($urandom_range(191, 128))
                                        : 8'($urandom_range(255, 245)));
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [7:0] opening_q[$];
        int         phase_end;
        opening_q = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF5, 8'hFF,
                      8'hC0, 8'h80,                   // overlong two-byte lead
                      8'hDF, 8'hBF,
                      8'hE0, 8'h80, 8'h80,
                      8'hF4, 8'hBF, 8'hBF, 8'hBF,     // largest code point
                      8'hE1, 8'h00, 8'hFF,            // continuations not checked
                      8'hF0, 8'hC3, 8'h7F, 8'h41};    // lead-like byte inside a run

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_q[i]) send_byte(opening_q[i]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            phase_end = opening_q.size() + (phase + 1) * (BYTE_TARGET - opening_q.size()) / 4;
            while (bytes_sent < phase_end) send_random_run();
            // Hold the sender until everything owed has come back.
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (board.pending() != 0);
        end

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes; checked %0d code points (%0d multi-byte, %0d replaced).",
                 bytes_sent, board.n_checked, board.n_multi, board.n_replaced);
        $display("Phases: free flow, sender idling, receiver stalls, both together.");
        if (board.n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
